@@ rtl/fully_connected_layer_defines.svh @@
// assertion macros for the fully connected layer
// expects signals named clk and rst in the including module
`ifndef FULLY_CONNECTED_LAYER_DEFINES_SVH
`define FULLY_CONNECTED_LAYER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FCL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define FCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/fcl_pkg.sv @@
// shared constants and types for the fully connected layer
// no dependencies
package fcl_pkg;

  // default sizes
  localparam int MAX_IN_DEF     = 64;
  localparam int MAX_OUT_DEF    = 64;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF  = 40;

  // fixed point format
  localparam int FRAC_BITS = 12;

  // fixed field widths
  localparam int ROW_W      = 6;
  localparam int COL_W      = 7;
  localparam int DIM_W      = 7;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_DIM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_DIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_EN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH    = 2'd3;

  // register reset values
  localparam logic [DIM_W-1:0]    IN_DIM_RST  = 7'd64;
  localparam logic [DIM_W-1:0]    OUT_DIM_RST = 7'd64;
  localparam logic                BIAS_EN_RST = 1'b1;
  localparam logic [SAMPLE_W-1:0] BATCH_RST   = 16'd1;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FEED = 1'b1;

  // side information carried with each result
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [ROW_W-1:0]    neuron;
    logic                last;
    logic                batch_end;
  } fcl_tag_t;

endpackage

@@ rtl/fcl_result_stage.sv @@
// bias add, rounding and saturation of accumulator values, two register stages
// depends on fcl_pkg
module fcl_result_stage import fcl_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  logic signed [ACC_WIDTH-1:0]  acc_val,
  input  logic signed [DATA_WIDTH-1:0] bias_val,
  input  logic                         bias_en,
  input  fcl_tag_t                     in_tag,
  output logic                         pending,
  output logic                         res_vld,
  output logic signed [DATA_WIDTH-1:0] res_value,
  output fcl_tag_t                     res_tag
);

  localparam int RW = ACC_WIDTH - FRAC_BITS + 1;
  localparam int CW = ((RW > DATA_WIDTH) ? RW : DATA_WIDTH) + 1;
  localparam logic signed [CW-1:0] SAT_HI =
    {{(CW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_LO = ~SAT_HI;

  logic                        sum_vld;
  logic signed [ACC_WIDTH-1:0] sum;
  fcl_tag_t                    sum_tag;
  logic signed [ACC_WIDTH-1:0] bias_sh;
  logic signed [ACC_WIDTH-1:0] quot;
  logic signed [CW-1:0]        rnd;
  logic signed [DATA_WIDTH-1:0] sat;

  // bias aligned to the accumulator fraction
  assign bias_sh = bias_en ? (ACC_WIDTH'(bias_val) <<< FRAC_BITS) : '0;

  // round half up, then clamp to the output range
  assign quot = sum >>> FRAC_BITS;
  assign rnd  = CW'(quot) + signed'({{(CW-1){1'b0}}, sum[FRAC_BITS-1]});

  always_comb begin
    if (rnd > SAT_HI) begin
      sat = SAT_HI[DATA_WIDTH-1:0];
    end else if (rnd < SAT_LO) begin
      sat = SAT_LO[DATA_WIDTH-1:0];
    end else begin
      sat = rnd[DATA_WIDTH-1:0];
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      sum_vld <= in_vld;
      res_vld <= sum_vld;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sum       <= acc_val + bias_sh;
    sum_tag   <= in_tag;
    res_value <= sat;
    res_tag   <= sum_tag;
  end

  assign pending = sum_vld;

endmodule

@@ rtl/fully_connected_layer.sv @@
// fully connected layer top level: weight memory, accumulator memory, sequencer
// depends on fcl_pkg, fcl_result_stage and fully_connected_layer_defines.svh
//
// Usage:
//   A request is taken when start is high and busy is low. opcode OP_LOAD writes
//   value into the weight memory at (weight_row, weight_col); column MAX_IN is
//   the bias of that row. A load leaves busy low.
//   opcode OP_FEED brings the next activation element of a sample. The element
//   is multiplied with one weight per used output neuron (N, out_dim_used clamped
//   to 1..MAX_OUT) through a single MAC that walks the weight memory one entry
//   per cycle, and busy stays high until the last product is written back.
//   The feed that completes a sample then sweeps the accumulators once more,
//   adding the bias if enabled, rounding and saturating; results come out one
//   per cycle, and busy falls when the last result has been shown. The pace is
//   set by the single read port of the weight memory.
//   Each result is shown for one cycle with result_valid high; the receiver
//   cannot stall, so nothing is held back.
//   Configuration writes go through cfg_valid / cfg_ready (always ready) and
//   must be made while busy is low; the block does not enforce it. Reset clears
//   the accumulators, element position and sample counter and restores register
//   defaults; the weight memory keeps no reset and must be loaded before use.
`include "fully_connected_layer_defines.svh"

module fully_connected_layer import fcl_pkg::*; #(
  parameter int MAX_IN     = MAX_IN_DEF,
  parameter int MAX_OUT    = MAX_OUT_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode,
  input  logic [ROW_W-1:0]             weight_row,
  input  logic [COL_W-1:0]             weight_col,
  input  logic signed [DATA_WIDTH-1:0] value,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // result channel
  output logic                         result_valid,
  output logic [SAMPLE_W-1:0]          sample_index,
  output logic [ROW_W-1:0]             neuron_index,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output logic                         is_last,
  output logic                         batch_end
);

  localparam int STORE_COLS  = MAX_IN + 1;
  localparam int STORE_DEPTH = MAX_OUT * STORE_COLS;
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int JW  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int EPW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
  localparam int PW  = 2 * DATA_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FEED,
    S_FEED_WAIT,
    S_EMIT,
    S_EMIT_WAIT
  } state_t;

  state_t state;

  // configuration registers
  logic [DIM_W-1:0]    in_dim_used;
  logic [DIM_W-1:0]    out_dim_used;
  logic                bias_enable;
  logic [SAMPLE_W-1:0] batch_count;

  // sequencer registers
  logic [JW-1:0]               j;
  logic [AW-1:0]               raddr;
  logic signed [DATA_WIDTH-1:0] act;
  logic [EPW-1:0]              elem_pos;
  logic [SAMPLE_W-1:0]         sample_cnt;

  // memories
  logic signed [DATA_WIDTH-1:0] wmem [STORE_DEPTH];
  logic signed [ACC_WIDTH-1:0]  amem [MAX_OUT];
  logic [MAX_OUT-1:0]           acc_valid;
  logic signed [DATA_WIDTH-1:0] w_rd;
  logic signed [ACC_WIDTH-1:0]  a_rd;
  logic                         a_rd_vld;

  // mac pipeline
  logic                        s1_vld;
  logic                        s2_vld;
  logic [JW-1:0]               s1_j;
  logic [JW-1:0]               s2_j;
  logic signed [PW-1:0]        prod;
  logic signed [ACC_WIDTH-1:0] acc_in;
  logic signed [ACC_WIDTH-1:0] acc_wd;

  // emit pipeline
  logic     e1_vld;
  fcl_tag_t e1_tag;
  fcl_tag_t res_tag;
  logic     pending;

  // derived control
  logic                 accept;
  logic                 feeding;
  logic                 load_we;
  logic [AW-1:0]        load_addr;
  logic [31:0]          nin_eff;
  logic [DIM_W-1:0]     nout_eff;
  logic [JW-1:0]        nout_m1;
  logic                 j_last;
  logic                 last_elem;
  logic [SAMPLE_W-1:0]  nb;
  logic                 closes;
  logic                 drain_done;
  logic signed [ACC_WIDTH-1:0] a_eff;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign feeding   = (state == S_FEED) || (state == S_FEED_WAIT);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_dim_used  <= IN_DIM_RST;
      out_dim_used <= OUT_DIM_RST;
      bias_enable  <= BIAS_EN_RST;
      batch_count  <= BATCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IN_DIM:  in_dim_used  <= cfg_data[DIM_W-1:0];
        REG_OUT_DIM: out_dim_used <= cfg_data[DIM_W-1:0];
        REG_BIAS_EN: bias_enable  <= cfg_data[0];
        REG_BATCH:   batch_count  <= cfg_data;
      endcase
    end
  end

  // clamped dimensions and end conditions
  always_comb begin
    if (in_dim_used == '0) begin
      nin_eff = 32'd1;
    end else if (32'(in_dim_used) > 32'(MAX_IN)) begin
      nin_eff = 32'(MAX_IN);
    end else begin
      nin_eff = 32'(in_dim_used);
    end
    if (out_dim_used == '0) begin
      nout_eff = DIM_W'(1);
    end else if (32'(out_dim_used) > 32'(MAX_OUT)) begin
      nout_eff = DIM_W'(MAX_OUT);
    end else begin
      nout_eff = out_dim_used;
    end
  end

  assign nout_m1   = JW'(nout_eff - DIM_W'(1));
  assign j_last    = (j == nout_m1);
  assign last_elem = ((32'(elem_pos) + 32'd1) >= nin_eff);
  assign nb        = (batch_count == '0) ? SAMPLE_W'(1) : batch_count;
  assign closes    = (({1'b0, sample_cnt} + 17'd1) >= {1'b0, nb});

  // weight load decode
  assign load_we   = accept && (opcode == OP_LOAD) &&
                     (32'(weight_row) < 32'(MAX_OUT)) &&
                     (32'(weight_col) <= 32'(MAX_IN));
  assign load_addr = AW'(32'(weight_row) * STORE_COLS + 32'(weight_col));

  // weight memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (load_we) begin
      wmem[load_addr] <= value;
    end
    w_rd <= wmem[raddr];
  end

  // accumulator memory, read at the sweep index, written from the mac
  assign acc_wd = acc_in + ACC_WIDTH'(prod);

  always_ff @(posedge clk) begin
    if (s2_vld) begin
      amem[s2_j] <= acc_wd;
    end
    a_rd <= amem[j];
  end

  // per-entry valid bits stand in for the cleared accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= '0;
      a_rd_vld  <= 1'b0;
    end else begin
      a_rd_vld <= acc_valid[j];
      if (drain_done && (state == S_EMIT_WAIT)) begin
        acc_valid <= '0;
      end else if (s2_vld) begin
        acc_valid[s2_j] <= 1'b1;
      end
    end
  end

  assign a_eff = a_rd_vld ? a_rd : '0;

  // mac and emit pipeline flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      e1_vld <= 1'b0;
    end else begin
      s1_vld <= (state == S_FEED);
      s2_vld <= s1_vld;
      e1_vld <= (state == S_EMIT);
    end
  end

  // mac and emit pipeline payload
  always_ff @(posedge clk) begin
    s1_j             <= j;
    s2_j             <= s1_j;
    prod             <= w_rd * act;
    acc_in           <= a_eff;
    e1_tag.sample    <= sample_cnt;
    e1_tag.neuron    <= ROW_W'(j);
    e1_tag.last      <= j_last;
    e1_tag.batch_end <= closes;
  end

  assign drain_done = (state == S_FEED_WAIT) ? (!s1_vld && !s2_vld)
                                             : (!e1_vld && !pending);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      j          <= '0;
      raddr      <= '0;
      elem_pos   <= '0;
      sample_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (opcode == OP_FEED)) begin
            act   <= value;
            j     <= '0;
            raddr <= AW'(elem_pos);
            state <= S_FEED;
          end
        end
        S_FEED: begin
          j     <= j + JW'(1);
          raddr <= raddr + AW'(STORE_COLS);
          if (j_last) begin
            state <= S_FEED_WAIT;
          end
        end
        S_FEED_WAIT: begin
          if (drain_done) begin
            if (last_elem) begin
              j     <= '0;
              raddr <= AW'(MAX_IN);
              state <= S_EMIT;
            end else begin
              elem_pos <= elem_pos + EPW'(1);
              state    <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          j     <= j + JW'(1);
          raddr <= raddr + AW'(STORE_COLS);
          if (j_last) begin
            state <= S_EMIT_WAIT;
          end
        end
        S_EMIT_WAIT: begin
          if (drain_done) begin
            elem_pos   <= '0;
            sample_cnt <= closes ? '0 : (sample_cnt + SAMPLE_W'(1));
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // bias, rounding and output registers
  fcl_result_stage #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_result (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (e1_vld),
    .acc_val   (a_eff),
    .bias_val  (w_rd),
    .bias_en   (bias_enable),
    .in_tag    (e1_tag),
    .pending   (pending),
    .res_vld   (result_valid),
    .res_value (out_value),
    .res_tag   (res_tag)
  );

  assign sample_index = res_tag.sample;
  assign neuron_index = res_tag.neuron;
  assign is_last      = res_tag.last;
  assign batch_end    = res_tag.batch_end;

  // checks
  `FCL_ASSERT_NOW(a_result_while_busy, result_valid, busy, "result outside a closing sweep")
  `FCL_ASSERT_NOW(a_acc_write_in_feed, s2_vld, feeding, "accumulator write outside a feed")
  `FCL_ASSERT_NEXT(a_last_ends_burst, result_valid && is_last, !result_valid, "result after last")
  `FCL_ASSERT_NEXT(a_feed_goes_busy, accept && (opcode == OP_FEED), busy, "feed did not go busy")

endmodule

@@ bench/tb_fully_connected_layer.sv @@
// self-checking bench for fully_connected_layer: a queue-fed driver, a result monitor
// and a Q4.12 dot-product predictor kept in step with every accepted request
// depends on fcl_pkg and the fully_connected_layer rtl
`timescale 1ns / 100ps

module tb_fully_connected_layer;
  import fcl_pkg::*;

  localparam int N_IN  = MAX_IN_DEF;
  localparam int N_OUT = MAX_OUT_DEF;
  localparam int DW    = DATA_WIDTH_DEF;
  localparam int AW    = ACC_WIDTH_DEF;
  // rows and columns with loaded weights and biases
  localparam int N_USE = 6;
  // longest busy stretch of a closing feed plus margin
  localparam int DRAIN_CYCLES = 2 * N_OUT + 16;
  localparam longint SAT_HI = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic             op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [DW-1:0]    val;
  } fcl_request_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [ROW_W-1:0]    neuron;
    logic [DW-1:0]       value;
    logic                last;
    logic                bend;
  } fcl_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  opcode = OP_LOAD;
  logic [ROW_W-1:0]      weight_row = '0;
  logic [COL_W-1:0]      weight_col = '0;
  logic [DW-1:0]         value = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IN_DIM;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  result_valid;
  logic [SAMPLE_W-1:0]   sample_index;
  logic [ROW_W-1:0]      neuron_index;
  logic [DW-1:0]         out_value;
  logic                  is_last;
  logic                  batch_end;

  fully_connected_layer uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .weight_row   (weight_row),
    .weight_col   (weight_col),
    .value        (value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .sample_index (sample_index),
    .neuron_index (neuron_index),
    .out_value    (out_value),
    .is_last      (is_last),
    .batch_end    (batch_end)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pending requests and the neuron outputs they will produce
  fcl_request_t pending_reqs[$];
  fcl_result_t  expected_results[$];
  fcl_request_t next_req;
  fcl_result_t  want;
  int           fail_count = 0;
  bit           steady = 1'b0;

  // shadow of the layer: weight/bias memory, accumulators, counters, registers
  logic signed [DW-1:0] weight_mem [N_OUT][N_IN+1];
  logic signed [AW-1:0] acc_mem [N_OUT];
  int                   elem_pos;
  int                   sample_cnt;
  logic [DIM_W-1:0]     cfg_in_dim;
  logic [DIM_W-1:0]     cfg_out_dim;
  logic                 cfg_bias;
  logic [SAMPLE_W-1:0]  cfg_batch;

  // apply one accepted request to the shadow state, queue any neuron outputs
  task automatic apply_request(input fcl_request_t req);
    int                     nin;
    int                     nout;
    int                     nb;
    int                     pos;
    int                     j;
    bit                     closes;
    logic signed [2*DW-1:0] prod;
    logic signed [DW-1:0]   bias_w;
    logic signed [AW-1:0]   sum;
    longint                 rounded;
    fcl_result_t            res;
    if (req.op == OP_LOAD) begin
      // out-of-range columns are dropped
      if (req.col <= N_IN) weight_mem[req.row][req.col] = req.val;
      return;
    end
    nin = cfg_in_dim;
    if (nin < 1) nin = 1;
    if (nin > N_IN) nin = N_IN;
    nout = cfg_out_dim;
    if (nout < 1) nout = 1;
    if (nout > N_OUT) nout = N_OUT;
    nb = (cfg_batch == 0) ? 1 : cfg_batch;
    pos = elem_pos % N_IN;
    // multiply-accumulate over the used outputs, wrapping at the accumulator width
    for (j = 0; j < nout; j++) begin
      prod = weight_mem[j][pos] * $signed(req.val);
      acc_mem[j] = acc_mem[j] + {{(AW - 2 * DW){prod[2*DW-1]}}, prod};
    end
    if (elem_pos + 1 < nin) begin
      elem_pos++;
      return;
    end
    // sample complete: bias, round half up, saturate
    closes = (sample_cnt + 1 >= nb);
    for (j = 0; j < nout; j++) begin
      sum = acc_mem[j];
      if (cfg_bias) begin
        bias_w = weight_mem[j][N_IN];
        sum = sum + ({{(AW - DW){bias_w[DW-1]}}, bias_w} << FRAC_BITS);
      end
      rounded = longint'(sum >>> FRAC_BITS);
      if (sum[FRAC_BITS-1]) rounded++;
      if (rounded > SAT_HI) rounded = SAT_HI;
      if (rounded < SAT_LO) rounded = SAT_LO;
      res.sample = sample_cnt[SAMPLE_W-1:0];
      res.neuron = j[ROW_W-1:0];
      res.value  = rounded[DW-1:0];
      res.last   = (j + 1 == nout);
      res.bend   = closes;
      expected_results.push_back(res);
    end
    for (j = 0; j < N_OUT; j++) acc_mem[j] = '0;
    elem_pos = 0;
    sample_cnt = closes ? 0 : ((sample_cnt + 1) & 16'hFFFF);
  endtask

  // request driver: feeds the queue, idles at random unless steady
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_request({opcode, weight_row, weight_col, value});
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
          next_req = pending_reqs.pop_front();
          start      <= 1'b1;
          opcode     <= next_req.op;
          weight_row <= next_req.row;
          weight_col <= next_req.col;
          value      <= next_req.val;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each strobed result with the oldest expected one
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: neuron_index %0d out_value %0d",
               neuron_index, $signed(out_value));
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (sample_index !== want.sample) begin
          $error("sample_index: expected %0d, actual %0d", want.sample, sample_index);
          fail_count++;
        end
        if (neuron_index !== want.neuron) begin
          $error("neuron_index: expected %0d, actual %0d", want.neuron, neuron_index);
          fail_count++;
        end
        if (out_value !== want.value) begin
          $error("out_value: expected %0d, actual %0d",
                 $signed(want.value), $signed(out_value));
          fail_count++;
        end
        if (is_last !== want.last) begin
          $error("is_last: expected %0d, actual %0d", want.last, is_last);
          fail_count++;
        end
        if (batch_end !== want.bend) begin
          $error("batch_end: expected %0d, actual %0d", want.bend, batch_end);
          fail_count++;
        end
      end
    end
  end

  // mix of full-range, small, extreme and mid-size Q4.12 values
  function automatic logic [DW-1:0] rand_value();
    logic [DW-1:0] v;
    case ($urandom_range(0, 3))
      0: v = DW'($urandom);
      1: v = DW'($urandom_range(0, 511) - 256);
      2: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          3: v = 16'hFFFF;
          default: v = 16'h0001;
        endcase
      end
      default: begin
        v = DW'($urandom);
        v = $signed(v) >>> 5;
      end
    endcase
    return v;
  endfunction

  task automatic push_load(input int row, input int col, input logic [DW-1:0] val);
    fcl_request_t req;
    req.op  = OP_LOAD;
    req.row = row[ROW_W-1:0];
    req.col = col[COL_W-1:0];
    req.val = val;
    pending_reqs.push_back(req);
  endtask

  // row and column are don't-care on a feed, so they carry noise
  task automatic push_feed(input logic [DW-1:0] val);
    fcl_request_t req;
    req.op  = OP_FEED;
    req.row = ROW_W'($urandom_range(0, 63));
    req.col = COL_W'($urandom_range(0, 127));
    req.val = val;
    pending_reqs.push_back(req);
  endtask

  task automatic random_load();
    if ($urandom_range(0, 99) < 80) push_load($urandom_range(0, 63), $urandom_range(0, 64),
                                              rand_value());
    else push_load($urandom_range(0, 63), $urandom_range(65, 127), rand_value());
  endtask

  // one register write, only issued while the layer is idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_IN_DIM:  cfg_in_dim  = data[DIM_W-1:0];
      REG_OUT_DIM: cfg_out_dim = data[DIM_W-1:0];
      REG_BIAS_EN: cfg_bias    = data[0];
      REG_BATCH:   cfg_batch   = data[SAMPLE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_layer(input logic [CFG_DATA_W-1:0] in_d, input logic [CFG_DATA_W-1:0] out_d,
                           input logic [CFG_DATA_W-1:0] bias, input logic [CFG_DATA_W-1:0] batch);
    cfg_write(REG_IN_DIM, in_d);
    cfg_write(REG_OUT_DIM, out_d);
    cfg_write(REG_BIAS_EN, bias);
    cfg_write(REG_BATCH, batch);
  endtask

  // hold off until every request is taken and every result has come, then let the sweep finish
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || start || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int r;
    int c;
    int ph;
    int k;
    int n_items;
    logic [CFG_DATA_W-1:0] in_d;
    logic [CFG_DATA_W-1:0] out_d;
    logic [CFG_DATA_W-1:0] batch;
    for (r = 0; r < N_OUT; r++) begin
      acc_mem[r] = '0;
      for (c = 0; c <= N_IN; c++) weight_mem[r][c] = '0;
    end
    elem_pos    = 0;
    sample_cnt  = 0;
    cfg_in_dim  = IN_DIM_RST;
    cfg_out_dim = OUT_DIM_RST;
    cfg_bias    = BIAS_EN_RST;
    cfg_batch   = BATCH_RST;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // weights and biases of the rows and columns in use; column 0 of every
    // row covers the clamped output count
    for (r = 0; r < N_OUT; r++) begin
      if (r < N_USE) begin
        for (c = 0; c < N_USE; c++) push_load(r, c, rand_value());
        push_load(r, N_IN, rand_value());
      end else begin
        push_load(r, 0, rand_value());
      end
    end
    wait_drained();

    // directed: extreme weights and biases, ignored loads, mid-sample load, saturation
    set_layer(2, 3, 1, 2);
    push_load(0, 0, 16'h7FFF);
    push_load(1, 0, 16'h8000);
    push_load(2, 0, 16'h0800);
    push_load(0, N_IN, 16'h7FFF);
    push_load(1, N_IN, 16'h8000);
    push_load(2, N_IN, 16'h0000);
    push_load(63, 127, 16'h5555);
    push_load(5, N_IN + 1, 16'hAAAA);
    push_feed(16'h8000);
    push_load(0, 1, 16'hFFFF);
    push_feed(16'h7FFF);
    push_feed(16'h0001);
    push_feed(16'hFFFF);
    wait_drained();

    // dimensions out of range, zero batch count, bias off
    set_layer(0, 16'hFFFF, 0, 0);
    push_feed(rand_value());
    wait_drained();

    // element count lowered below the position reached mid-sample
    set_layer(3, 1, 1, 5);
    push_feed(rand_value());
    push_feed(rand_value());
    wait_drained();
    cfg_write(REG_IN_DIM, 1);
    push_feed(rand_value());
    push_feed(rand_value());
    push_feed(rand_value());
    wait_drained();

    // batch count lowered below the sample counter
    cfg_write(REG_BATCH, 2);
    push_feed(rand_value());
    wait_drained();

    // random phases over the loaded rows and columns; one runs without idling
    for (ph = 0; ph < 8; ph++) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0: in_d = '0;
        1: in_d = {9'($urandom_range(0, 511)), 7'($urandom_range(0, N_USE))};
        default: in_d = CFG_DATA_W'($urandom_range(1, N_USE));
      endcase
      case ($urandom_range(0, 9))
        0: out_d = '0;
        1: out_d = {9'($urandom_range(0, 511)), 7'($urandom_range(0, N_USE))};
        default: out_d = CFG_DATA_W'($urandom_range(1, N_USE));
      endcase
      case ($urandom_range(0, 9))
        0: batch = '0;
        1: batch = 16'hFFFF;
        2: batch = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
        default: batch = CFG_DATA_W'($urandom_range(1, 4));
      endcase
      set_layer(in_d, out_d, CFG_DATA_W'($urandom_range(0, 1)), batch);
      steady = (ph == 2);
      n_items = steady ? 20 : 8;
      for (k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) < 80) push_feed(rand_value());
        else random_load();
      end
    end
    wait_drained();

    if (fail_count == 0) begin
      $display("PASS fully_connected_layer");
    end else begin
      $display("FAIL fully_connected_layer");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL fully_connected_layer");
    $finish;
  end

endmodule
